FILE: hdl/zpc_pkg.sv
// Shared constants, types and fixed-point helpers of the ZMP preview controller.
package zpc_pkg;

	localparam int PREVIEW_LEN = 128;
	localparam int IDX_W = $clog2(PREVIEW_LEN);
	localparam int OP_W = $clog2(PREVIEW_LEN + 5);

	localparam logic [1:0] CMD_STEP = 2'd0;
	localparam logic [1:0] CMD_LOAD = 2'd1;
	localparam logic [1:0] CMD_FILL = 2'd2;

	localparam logic [2:0] REG_STEP_DT = 3'd0;
	localparam logic [2:0] REG_HALF_DT_SQ = 3'd1;
	localparam logic [2:0] REG_SIXTH_DT_CUBE = 3'd2;
	localparam logic [2:0] REG_HEIGHT_OVER_G = 3'd3;
	localparam logic [2:0] REG_GAIN_INTEGRAL = 3'd4;
	localparam logic [2:0] REG_GAIN_POS = 3'd5;
	localparam logic [2:0] REG_GAIN_VEL = 3'd6;
	localparam logic [2:0] REG_GAIN_ACC = 3'd7;

	typedef struct packed {
		logic rot;
		logic shift;
		logic fill;
		logic load;
	} cell_ctl_t;

	typedef struct packed {
		logic issue;
		logic rnd;
		logic clr;
	} mac_ctl_t;

	function automatic logic signed [63:0] rnd16(input logic signed [63:0] v);
		logic signed [63:0] t;
		t = v + 64'sd32768;
		return t >>> 16;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (v < -64'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
		if (v > 50'sh07fffffffffff) begin
			return 48'sh7fffffffffff;
		end else if (v < -50'sh0800000000000) begin
			return 48'sh800000000000;
		end
		return v[47:0];
	endfunction

endpackage

FILE: hdl/zpc_cell.sv
// One preview window cell: reference pair and preview gain of one window position.
module zpc_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  zpc_pkg::cell_ctl_t         ctl,
	input  logic [zpc_pkg::IDX_W-1:0]  my_idx,
	input  logic [zpc_pkg::IDX_W-1:0]  gidx,
	input  logic signed [31:0]         gval,
	input  logic signed [31:0]         fill_x,
	input  logic signed [31:0]         fill_y,
	input  logic signed [31:0]         nx_wx,
	input  logic signed [31:0]         nx_wy,
	input  logic signed [31:0]         nx_g,
	output logic signed [31:0]         wx,
	output logic signed [31:0]         wy,
	output logic signed [31:0]         g
);

	logic signed [31:0] wx_q, wy_q, g_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wx_q <= '0;
			wy_q <= '0;
		end else if (ctl.fill) begin
			wx_q <= fill_x;
			wy_q <= fill_y;
		end else if (ctl.rot || ctl.shift) begin
			wx_q <= nx_wx;
			wy_q <= nx_wy;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rot) begin
			g_q <= nx_g;
		end else if (ctl.load && gidx == my_idx) begin
			g_q <= gval;
		end
	end

	assign wx = wx_q;
	assign wy = wy_q;
	assign g = g_q;

endmodule

FILE: hdl/zpc_mac.sv
// Shared multiply-accumulate unit with a registered product and optional rounding.
module zpc_mac (
	input  logic                clk,
	input  logic                arst_n,
	input  zpc_pkg::mac_ctl_t   ctl,
	input  logic signed [32:0]  a,
	input  logic signed [32:0]  b,
	output logic signed [63:0]  acc
);

	logic signed [65:0] prod;
	logic signed [63:0] prod_s1, term;
	logic v_s1, rnd_s1;
	logic signed [63:0] acc_q;

	assign prod = a * b;
	assign term = rnd_s1 ? zpc_pkg::rnd16(prod_s1) : prod_s1;

	always_ff @(posedge clk) begin
		prod_s1 <= prod[63:0];
		rnd_s1 <= ctl.rnd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			acc_q <= '0;
		end else begin
			v_s1 <= ctl.issue;
			if (ctl.clr) begin
				acc_q <= '0;
			end else if (v_s1) begin
				acc_q <= acc_q + term;
			end
		end
	end

	assign acc = acc_q;

endmodule

FILE: hdl/zmp_preview_controller.sv
// Top level of the two-axis ZMP preview controller with its step sequencer.
//
// Input words arrive on s_tvalid/s_tready/s_tdata with the command in s_tuser.
// A load word writes one preview gain, a fill word sets the whole window to
// the given reference and clears model state and integral; neither produces
// output. A step word shifts the window, updates the error integral and then
// runs the shared MAC: per axis one lap around the cell chain for the preview
// sum plus the integral, state gain and model rows, all on the one multiplier.
// No new input word is taken while a step runs. The result word leaves on
// m_tvalid/m_tready/m_tdata from an output register. While that word waits
// for the receiver new input is taken; a step that finishes while the old
// word still waits holds, with s_tready low, until it is gone.
// Steps before the first fill word give no output and change nothing.
// Reset clears the window, model state and integral and returns the
// configuration to its defaults; preview gains are undefined until loaded.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must
// write it only while idle, as the block itself does not enforce this.
module zmp_preview_controller (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	// ref_x, ref_y, gain_index, gain_value, zero pad
	input  logic [103:0]  s_tdata,
	// cmd
	input  logic [1:0]    s_tuser,
	output logic          m_tvalid,
	input  logic          m_tready,
	// com_x, com_y, vel_x, vel_y, acc_x, acc_y, zmp_x, zmp_y
	output logic [255:0]  m_tdata,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_index,
	input  logic [31:0]   cfg_data
);

	localparam int N = zpc_pkg::PREVIEW_LEN;
	localparam int OW = zpc_pkg::OP_W;

	typedef enum logic [2:0] {S_IDLE, S_ISSUE, S_DRAIN, S_REDUCE, S_OUT} state_t;
	typedef enum logic [2:0] {G_CTRL, G_N0, G_N1, G_N2, G_ZMP} grp_t;

	state_t st_q;
	grp_t grp_q;
	logic [OW-1:0] op_q, last_op;
	logic axis_q, ready_q;

	logic [15:0] dt_q, h2_q, c3_q, hog_q;
	logic signed [31:0] gi_q, gp_q, gv_q, ga_q;

	logic signed [31:0] now_q [2][3];
	logic signed [31:0] dly_q [2][3];
	logic signed [47:0] integ_q [2];
	logic signed [31:0] zmp_q [2];
	logic signed [31:0] nn_q [3];
	logic signed [31:0] u_q;

	logic signed [31:0] wx_c [N];
	logic signed [31:0] wy_c [N];
	logic signed [31:0] g_c [N];
	logic signed [31:0] tail_x, tail_y;

	logic signed [31:0] ref_x, ref_y, gain_value;
	logic [6:0] gain_index;
	logic in_acc, acc_step, acc_fill, acc_load;

	zpc_pkg::cell_ctl_t cctl;
	zpc_pkg::mac_ctl_t mctl;
	logic signed [32:0] a_op, b_op;
	logic rnd_sel, rot_sel;
	logic signed [63:0] acc;
	logic signed [31:0] red_model, red_u;
	logic signed [31:0] win0, d0, d1, d2, n0, n2;
	logic signed [47:0] integ;

	localparam logic signed [32:0] ONE = 33'sd65536;

	assign ref_x = s_tdata[31:0];
	assign ref_y = s_tdata[63:32];
	assign gain_index = s_tdata[70:64];
	assign gain_value = s_tdata[102:71];

	assign s_tready = (st_q == S_IDLE);
	assign in_acc = s_tvalid && s_tready;
	assign acc_step = in_acc && s_tuser == zpc_pkg::CMD_STEP && ready_q;
	assign acc_fill = in_acc && s_tuser == zpc_pkg::CMD_FILL;
	assign acc_load = in_acc && s_tuser == zpc_pkg::CMD_LOAD
		&& (32'(gain_index) < 32'(N));

	always_comb begin
		cctl.rot = (st_q == S_ISSUE) && rot_sel;
		cctl.shift = acc_step;
		cctl.fill = acc_fill;
		cctl.load = acc_load;
		mctl.issue = (st_q == S_ISSUE);
		mctl.rnd = rnd_sel;
		mctl.clr = (st_q == S_REDUCE);
	end

	assign tail_x = cctl.rot ? wx_c[0] : ref_x;
	assign tail_y = cctl.rot ? wy_c[0] : ref_y;

	for (genvar i = 0; i < N; i++) begin : g_cells
		logic signed [31:0] nwx, nwy, ng;
		if (i == N - 1) begin : g_tail
			assign nwx = tail_x;
			assign nwy = tail_y;
			assign ng = g_c[0];
		end else begin : g_mid
			assign nwx = wx_c[i+1];
			assign nwy = wy_c[i+1];
			assign ng = g_c[i+1];
		end
		zpc_cell u_cell (
			.clk(clk), .arst_n(arst_n), .ctl(cctl),
			.my_idx(zpc_pkg::IDX_W'(i)),
			.gidx(zpc_pkg::IDX_W'(gain_index)), .gval(gain_value),
			.fill_x(ref_x), .fill_y(ref_y),
			.nx_wx(nwx), .nx_wy(nwy), .nx_g(ng),
			.wx(wx_c[i]), .wy(wy_c[i]), .g(g_c[i])
		);
	end

	zpc_mac u_mac (
		.clk(clk), .arst_n(arst_n), .ctl(mctl), .a(a_op), .b(b_op), .acc(acc)
	);

	assign win0 = axis_q ? wy_c[0] : wx_c[0];
	assign d0 = dly_q[axis_q][0];
	assign d1 = dly_q[axis_q][1];
	assign d2 = dly_q[axis_q][2];
	assign n0 = now_q[axis_q][0];
	assign n2 = now_q[axis_q][2];
	assign integ = integ_q[axis_q];

	always_comb begin
		a_op = '0;
		b_op = '0;
		rnd_sel = 1'b0;
		rot_sel = 1'b0;
		case (grp_q)
			G_CTRL: begin
				rnd_sel = 1'b1;
				a_op = {gi_q[31], gi_q};
				if (op_q == OW'(0)) begin
					rnd_sel = 1'b0;
					b_op = {integ[47], integ[47:16]};
				end else if (op_q == OW'(1)) begin
					b_op = {17'b0, integ[15:0]};
				end else if (op_q <= OW'(N + 1)) begin
					rot_sel = 1'b1;
					a_op = {g_c[0][31], g_c[0]};
					b_op = {win0[31], win0};
				end else if (op_q == OW'(N + 2)) begin
					a_op = {gp_q[31], gp_q};
					b_op = {d0[31], d0};
				end else if (op_q == OW'(N + 3)) begin
					a_op = {gv_q[31], gv_q};
					b_op = {d1[31], d1};
				end else begin
					a_op = {ga_q[31], ga_q};
					b_op = {d2[31], d2};
				end
			end
			G_N0: begin
				if (op_q == OW'(0)) begin
					a_op = {d0[31], d0};
					b_op = ONE;
				end else if (op_q == OW'(1)) begin
					a_op = {17'b0, dt_q};
					b_op = {d1[31], d1};
				end else if (op_q == OW'(2)) begin
					a_op = {17'b0, h2_q};
					b_op = {d2[31], d2};
				end else begin
					a_op = {17'b0, c3_q};
					b_op = {u_q[31], u_q};
				end
			end
			G_N1: begin
				if (op_q == OW'(0)) begin
					a_op = {d1[31], d1};
					b_op = ONE;
				end else if (op_q == OW'(1)) begin
					a_op = {17'b0, dt_q};
					b_op = {d2[31], d2};
				end else begin
					a_op = {17'b0, h2_q};
					b_op = {u_q[31], u_q};
				end
			end
			G_N2: begin
				if (op_q == OW'(0)) begin
					a_op = {d2[31], d2};
					b_op = ONE;
				end else begin
					a_op = {17'b0, dt_q};
					b_op = {u_q[31], u_q};
				end
			end
			G_ZMP: begin
				if (op_q == OW'(0)) begin
					a_op = {n0[31], n0};
					b_op = ONE;
				end else begin
					a_op = -$signed({17'b0, hog_q});
					b_op = {n2[31], n2};
				end
			end
			default: begin
				a_op = '0;
			end
		endcase
	end

	always_comb begin
		case (grp_q)
			G_CTRL: last_op = OW'(N + 4);
			G_N0: last_op = OW'(3);
			G_N1: last_op = OW'(2);
			default: last_op = OW'(1);
		endcase
	end

	assign red_model = zpc_pkg::sat32(zpc_pkg::rnd16(acc));
	assign red_u = zpc_pkg::sat32(-acc);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q <= 16'd66;
			h2_q <= '0;
			c3_q <= '0;
			hog_q <= 16'd5345;
			gi_q <= '0;
			gp_q <= '0;
			gv_q <= '0;
			ga_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				zpc_pkg::REG_STEP_DT: dt_q <= cfg_data[15:0];
				zpc_pkg::REG_HALF_DT_SQ: h2_q <= cfg_data[15:0];
				zpc_pkg::REG_SIXTH_DT_CUBE: c3_q <= cfg_data[15:0];
				zpc_pkg::REG_HEIGHT_OVER_G: hog_q <= cfg_data[15:0];
				zpc_pkg::REG_GAIN_INTEGRAL: gi_q <= cfg_data;
				zpc_pkg::REG_GAIN_POS: gp_q <= cfg_data;
				zpc_pkg::REG_GAIN_VEL: gv_q <= cfg_data;
				zpc_pkg::REG_GAIN_ACC: ga_q <= cfg_data;
				default: dt_q <= dt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == S_REDUCE) begin
			case (grp_q)
				G_CTRL: u_q <= red_u;
				G_N0: nn_q[0] <= red_model;
				G_N1: nn_q[1] <= red_model;
				G_N2: nn_q[2] <= red_model;
				default: u_q <= u_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			grp_q <= G_CTRL;
			op_q <= '0;
			axis_q <= 1'b0;
			ready_q <= 1'b0;
			m_tvalid <= 1'b0;
			m_tdata <= '0;
			for (int a = 0; a < 2; a++) begin
				integ_q[a] <= '0;
				zmp_q[a] <= '0;
				for (int k = 0; k < 3; k++) begin
					now_q[a][k] <= '0;
					dly_q[a][k] <= '0;
				end
			end
		end else begin
			if (m_tvalid && m_tready && st_q != S_OUT) begin
				m_tvalid <= 1'b0;
			end
			case (st_q)
				S_IDLE: begin
					if (acc_fill) begin
						ready_q <= 1'b1;
						for (int a = 0; a < 2; a++) begin
							integ_q[a] <= '0;
							zmp_q[a] <= '0;
							for (int k = 0; k < 3; k++) begin
								now_q[a][k] <= '0;
								dly_q[a][k] <= '0;
							end
						end
					end else if (acc_step) begin
						integ_q[0] <= zpc_pkg::sat48(50'(integ_q[0]) + 50'(zmp_q[0])
							- 50'(wx_c[1]));
						integ_q[1] <= zpc_pkg::sat48(50'(integ_q[1]) + 50'(zmp_q[1])
							- 50'(wy_c[1]));
						st_q <= S_ISSUE;
						grp_q <= G_CTRL;
						op_q <= '0;
						axis_q <= 1'b0;
					end
				end
				S_ISSUE: begin
					if (op_q == last_op) begin
						op_q <= '0;
						st_q <= S_DRAIN;
					end else begin
						op_q <= op_q + OW'(1);
					end
				end
				S_DRAIN: begin
					st_q <= S_REDUCE;
				end
				S_REDUCE: begin
					st_q <= S_ISSUE;
					case (grp_q)
						G_CTRL: grp_q <= G_N0;
						G_N0: grp_q <= G_N1;
						G_N1: grp_q <= G_N2;
						G_N2: grp_q <= G_ZMP;
						default: begin
							grp_q <= G_CTRL;
							zmp_q[axis_q] <= red_model;
							for (int k = 0; k < 3; k++) begin
								dly_q[axis_q][k] <= now_q[axis_q][k];
								now_q[axis_q][k] <= nn_q[k];
							end
							if (axis_q) begin
								st_q <= S_OUT;
							end
							axis_q <= !axis_q;
						end
					endcase
				end
				S_OUT: begin
					if (!m_tvalid || m_tready) begin
						m_tvalid <= 1'b1;
						m_tdata <= {zmp_q[1], zmp_q[0], now_q[1][2], now_q[0][2],
							now_q[1][1], now_q[0][1], now_q[1][0], now_q[0][0]};
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	a_no_rot_and_shift: assert property (@(posedge clk) disable iff (!arst_n)
		!(cctl.rot && (cctl.shift || cctl.fill)))
		else $error("window rotates while shifting or filling");

	a_reduce_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_REDUCE) |-> $past(st_q) == S_DRAIN)
		else $error("reduce without drained accumulator");

	a_step_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && s_tuser == zpc_pkg::CMD_STEP && !ready_q) |=> st_q == S_IDLE)
		else $error("step accepted before fill started work");

	a_out_after_both_axes: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_OUT && $past(st_q) == S_REDUCE) |-> !axis_q && $past(axis_q))
		else $error("output before both axes are done");

endmodule
